// ===== rtl/lrfd_pkg.sv =====
// ----------------------------------------------------------------------------
// lrfd_pkg
// shared types and constants of the lidar range frame deframer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lrfd_pkg;

   localparam int BEAMS_DEF = 200;

   localparam int BYTE_W  = 8;
   localparam int RANGE_W = 16;
   localparam int DIFF_W  = 17;
   localparam int KIND_W  = 2;
   localparam int BEAM_W  = 8;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;

   localparam logic [BYTE_W-1:0] START_BYTE  = 8'h02;
   localparam logic [BYTE_W-1:0] SECOND_BYTE = 8'h00;
   localparam logic [BYTE_W-1:0] END_BYTE    = 8'h03;

   localparam logic [KIND_W-1:0] KIND_BEAM   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_MAX_RANGE = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET    = 8'd1;

   localparam logic [RANGE_W-1:0] MAX_RANGE_RST = 16'd20000;
   localparam logic [RANGE_W-1:0] OFFSET_RST    = 16'd7200;

   typedef struct packed {
      logic                     valid;
      logic [KIND_W-1:0]        kind;
      logic [BEAM_W-1:0]        beam_index;
      logic signed [DIFF_W-1:0] range_mm;
   } rslt_type;

endpackage

`default_nettype wire

// ===== rtl/lrfd_parser.sv =====
// ----------------------------------------------------------------------------
// lrfd_parser
// frame state machine, beam pairing, clamp and offset for one byte beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lrfd_parser
   import lrfd_pkg::*;
#(
   parameter int BEAMS = BEAMS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               beat_fire,
   input  wire logic [BYTE_W-1:0]  rx_byte,
   input  wire logic [RANGE_W-1:0] max_range_mm,
   input  wire logic [RANGE_W-1:0] offset_mm,
   output rslt_type                rslt
);

   localparam int CNT_W = $clog2(2 * BEAMS + 1);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(2 * BEAMS - 1);

   localparam logic [1:0] PH_HUNT    = 2'd0;
   localparam logic [1:0] PH_SECOND  = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;
   localparam logic [1:0] PH_END     = 2'd3;

   logic [1:0]        phase_ff, phase_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [BYTE_W-1:0] high_ff, high_in;

   logic [RANGE_W-1:0] raw;
   logic [RANGE_W-1:0] clamped;

   assign raw     = {high_ff, rx_byte};
   assign clamped = (raw > max_range_mm) ? '0 : raw;

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      high_in  = high_ff;
      rslt     = '0;
      unique case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == START_BYTE) begin
               phase_in = PH_SECOND;
            end
         end
         PH_SECOND: begin
            if (rx_byte == SECOND_BYTE) begin
               phase_in = PH_PAYLOAD;
               cnt_in   = '0;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_PAYLOAD: begin
            cnt_in = cnt_ff + 1'b1;
            if (!cnt_ff[0]) begin
               high_in = rx_byte;
            end else begin
               rslt.valid      = 1'b1;
               rslt.kind       = KIND_BEAM;
               rslt.beam_index = BEAM_W'(cnt_ff >> 1);
               rslt.range_mm   = $signed({1'b0, clamped} - {1'b0, offset_mm});
               if (cnt_ff == LAST_CNT) begin
                  phase_in = PH_END;
               end
            end
         end
         PH_END: begin
            rslt.valid = 1'b1;
            rslt.kind  = (rx_byte == END_BYTE) ? KIND_ACCEPT : KIND_REJECT;
            phase_in   = PH_HUNT;
            cnt_in     = '0;
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
      if (!beat_fire) begin
         phase_in   = phase_ff;
         cnt_in     = cnt_ff;
         high_in    = high_ff;
         rslt.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         cnt_ff   <= '0;
         high_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         high_ff  <= high_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/lidar_range_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// lidar_range_frame_deframer_top
// byte stream in, beam ranges and frame verdicts out
//
//   channel  dir  payload                                  handshake
//   req_     in   tdata[7:0] rx_byte                       tvalid/tready
//   rsp_     out  tuser kind, tdata beam_index, range_mm   tvalid/tready
//   csr_     in   index 0 max_range_mm, 1 offset_mm        wr_en only
//
// one byte beat per cycle while req_tready is high; a result is registered and appears in the cycle after its byte
// the output register holds the result while the next byte is taken
// req_tready drops only while a result waits and rsp_tready is low
// synchronous reset returns the parser to hunting and loads default limits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lidar_range_frame_deframer_top
   import lrfd_pkg::*;
#(
   parameter int BEAMS = BEAMS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [BYTE_W-1:0]     req_tdata,   // [7:0] rx_byte
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // [7:0] beam_index, [24:8] range_mm
   output logic [KIND_W-1:0]          rsp_tuser,   // [1:0] kind
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [RANGE_W-1:0] max_range_ff;
   logic [RANGE_W-1:0] offset_ff;

   logic     beat_fire;
   rslt_type rslt;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]        rsp_kind_ff;
   logic [BEAM_W-1:0]        rsp_index_ff;
   logic signed [DIFF_W-1:0] rsp_range_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_range_ff <= MAX_RANGE_RST;
         offset_ff    <= OFFSET_RST;
      end else if (csr_wr_en) begin
         if (csr_index == REG_MAX_RANGE) begin
            max_range_ff <= csr_wdata;
         end else if (csr_index == REG_OFFSET) begin
            offset_ff <= csr_wdata;
         end
      end
   end

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign beat_fire  = req_tvalid && req_tready;

   lrfd_parser #(
      .BEAMS (BEAMS)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .beat_fire    (beat_fire),
      .rx_byte      (req_tdata),
      .max_range_mm (max_range_ff),
      .offset_mm    (offset_ff),
      .rslt         (rslt)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (beat_fire) begin
         rsp_valid_in = rslt.valid;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (beat_fire && rslt.valid) begin
         rsp_kind_ff  <= rslt.kind;
         rsp_index_ff <= rslt.beam_index;
         rsp_range_ff <= rslt.range_mm;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - DIFF_W - BEAM_W){1'b0}}, rsp_range_ff, rsp_index_ff};

endmodule

`default_nettype wire

// ===== rtl/lrfd_checker.sv =====
// ----------------------------------------------------------------------------
// lrfd_checker
// port-level checks on the deframer result stream
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lrfd_checker
   import lrfd_pkg::*;
#(
   parameter int BEAMS = BEAMS_DEF
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [KIND_W-1:0]     rsp_tuser
);

   localparam logic [BEAM_W-1:0] LAST_BEAM = BEAM_W'(BEAMS - 1);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp beat changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp beat right after reset");

   a_no_bubble: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req stalled with empty output");

   a_verdict_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_BEAM |->
         rsp_tdata == '0 && (rsp_tuser == KIND_ACCEPT || rsp_tuser == KIND_REJECT))
      else $error("frame verdict with nonzero data or bad kind");

   a_beam_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_BEAM |->
         rsp_tdata[BEAM_W-1:0] <= LAST_BEAM)
      else $error("beam index past frame length");

endmodule

bind lidar_range_frame_deframer_top lrfd_checker #(
   .BEAMS (BEAMS)
) u_lrfd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
